// ===== rtl/dgj_pkg.sv =====
// ============================================================================
// dgj_pkg
// Shared types, constants and arithmetic helpers for the DH Jacobian block.
// ============================================================================
package dgj_pkg;

    localparam int MAX_JOINTS_DEF = 16;

    localparam logic signed [31:0] Q_ONE     = 32'sd65536;
    localparam logic signed [19:0] Q_PI      = 20'sd205887;
    localparam logic signed [19:0] Q_HALF_PI = 20'sd102944;
    localparam logic signed [19:0] Q_TWO_PI  = 20'sd411775;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam int CORDIC_STEPS = 16;

    typedef struct packed {
        logic signed [31:0] joint_value;
        logic signed [31:0] link_length;
        logic signed [31:0] link_twist;
        logic signed [31:0] link_offset;
        logic signed [31:0] joint_angle;
        logic signed [31:0] joint_zero_offset;
        logic               revolute;
        logic               last_joint;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] lin_x;
        logic signed [31:0] lin_y;
        logic signed [31:0] lin_z;
        logic signed [31:0] ang_x;
        logic signed [31:0] ang_y;
        logic signed [31:0] ang_z;
        logic [3:0]         column_index;
        logic               last_column;
    } t_out_item;

    // A joint after the front end has resolved which DH term the joint value moves.
    typedef struct packed {
        logic signed [33:0] turn;
        logic signed [31:0] twist;
        logic signed [31:0] len;
        logic signed [31:0] depth;
        logic               rev;
        logic               fin;
    } t_job;

    typedef struct packed {
        logic signed [31:0] sin_v;
        logic signed [31:0] cos_v;
    } t_sc;

    typedef struct packed {
        logic busy;
        logic valid;
    } t_cor_stat;

    typedef enum logic [2:0] {
        C_IDLE, C_RED, C_FOLD, C_ROT, C_FIN
    } t_cor_state;

    typedef enum logic [3:0] {
        B_IDLE, B_TRIG, B_MUL, B_ACC, B_UPDATE, B_RD, B_RDW, B_EMIT
    } t_back_state;

    typedef enum logic [1:0] {
        M_LINK, M_PROD, M_COL
    } t_mode;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Q16.16 product rounding: add one half and shift with floor.
    function automatic logic signed [47:0] qround(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + 64'sd32768) >>> 16;
        return t[47:0];
    endfunction

    function automatic logic signed [19:0] atan_q(input logic [3:0] k);
        case (k)
            4'd0:    return 20'sd51472;
            4'd1:    return 20'sd30386;
            4'd2:    return 20'sd16055;
            4'd3:    return 20'sd8150;
            4'd4:    return 20'sd4091;
            4'd5:    return 20'sd2047;
            4'd6:    return 20'sd1024;
            4'd7:    return 20'sd512;
            4'd8:    return 20'sd256;
            4'd9:    return 20'sd128;
            4'd10:   return 20'sd64;
            4'd11:   return 20'sd32;
            4'd12:   return 20'sd16;
            4'd13:   return 20'sd8;
            4'd14:   return 20'sd4;
            default: return 20'sd2;
        endcase
    endfunction

endpackage

// ===== rtl/dgj_ram.sv =====
// ============================================================================
// dgj_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module dgj_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/dgj_front.sv =====
// ============================================================================
// dgj_front
// Accepts joints, resolves the varying DH term and queues them for the back end.
// ============================================================================
module dgj_front import dgj_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_item i_item,
    output logic     o_job_valid,
    output t_job     o_job,
    input  logic     i_job_pop
);
    localparam int QD = 2;

    t_job       r_q [QD];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_job       s_job;
    logic       s_wr;

    // A revolute joint moves the angle, a prismatic one the offset.
    always_comb begin
        s_job.turn  = 34'(i_item.joint_angle);
        s_job.depth = i_item.link_offset;
        if (i_item.revolute) begin
            s_job.turn = 34'(i_item.joint_angle) + 34'(i_item.joint_value)
                       + 34'(i_item.joint_zero_offset);
        end else begin
            s_job.depth = sat32(64'(i_item.link_offset) + 64'(i_item.joint_value)
                              + 64'(i_item.joint_zero_offset));
        end
        s_job.twist = i_item.link_twist;
        s_job.len   = i_item.link_length;
        s_job.rev   = i_item.revolute;
        s_job.fin   = i_item.last_joint;
    end

    assign full        = (r_cnt == 2'(QD));
    assign s_wr        = push && !full;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            r_q[r_wp] <= s_job;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (s_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_job_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(s_wr) - 2'(i_job_pop);
        end
    end
endmodule

// ===== rtl/dgj_cordic.sv =====
// ============================================================================
// dgj_cordic
// Iterative sine and cosine: range reduction, quadrant fold, 16 rotations.
// ============================================================================
module dgj_cordic import dgj_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [33:0] i_angle,
    output t_cor_stat          o_stat,
    output t_sc                o_sc
);
    t_cor_state         r_state;
    t_cor_state         n_state;
    logic [35:0]        r_z;
    logic signed [19:0] r_za;
    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic [3:0]         r_k;
    logic               r_flip;
    logic               r_valid;
    logic [35:0]        s_sub;
    logic signed [19:0] s_zr;
    logic signed [19:0] s_zf;
    logic               s_flip;
    logic signed [33:0] s_xr;
    logic signed [33:0] s_yr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            C_IDLE: if (i_start) n_state = C_RED;
            C_RED:  if (r_k == 4'd0) n_state = C_FOLD;
            C_FOLD: n_state = C_ROT;
            C_ROT:  if (r_k == 4'(CORDIC_STEPS - 1)) n_state = C_FIN;
            C_FIN:  n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_comb begin
        s_sub  = 36'(Q_TWO_PI) << r_k;
        s_zr   = r_z[19:0];
        if (s_zr > Q_PI) begin
            s_zr = s_zr - Q_TWO_PI;
        end
        s_zf   = s_zr;
        s_flip = 1'b0;
        if (s_zr > Q_HALF_PI) begin
            s_zf   = s_zr - Q_PI;
            s_flip = 1'b1;
        end else if (s_zr < -Q_HALF_PI) begin
            s_zf   = s_zr + Q_PI;
            s_flip = 1'b1;
        end
        s_xr = (r_x + 34'sd8192) >>> 14;
        s_yr = (r_y + 34'sd8192) >>> 14;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    // Adding a multiple of 2pi makes the angle positive.
                    r_z <= (i_angle < 0) ? 36'(i_angle) + (36'(Q_TWO_PI) << 15)
                                         : 36'(i_angle);
                    r_k <= 4'd15;
                end
            end
            C_RED: begin
                if (r_z >= s_sub) begin
                    r_z <= r_z - s_sub;
                end
                r_k <= r_k - 4'd1;
            end
            C_FOLD: begin
                r_za   <= s_zf;
                r_flip <= s_flip;
                r_x    <= CORDIC_GAIN;
                r_y    <= '0;
                r_k    <= 4'd0;
            end
            C_ROT: begin
                if (r_za >= 0) begin
                    r_x  <= r_x - (r_y >>> r_k);
                    r_y  <= r_y + (r_x >>> r_k);
                    r_za <= r_za - atan_q(r_k);
                end else begin
                    r_x  <= r_x + (r_y >>> r_k);
                    r_y  <= r_y - (r_x >>> r_k);
                    r_za <= r_za + atan_q(r_k);
                end
                r_k <= r_k + 4'd1;
            end
            C_FIN: begin
                o_sc.cos_v <= r_flip ? -s_xr[31:0] : s_xr[31:0];
                o_sc.sin_v <= r_flip ? -s_yr[31:0] : s_yr[31:0];
            end
            default: begin
            end
        endcase
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (r_state == C_IDLE && i_start) begin
            r_valid <= 1'b0;
        end else if (r_state == C_FIN) begin
            r_valid <= 1'b1;
        end
    end

    assign o_stat.busy  = (r_state != C_IDLE);
    assign o_stat.valid = r_valid;
endmodule

// ===== rtl/dgj_back.sv =====
// ============================================================================
// dgj_back
// Records joint frames, builds the link matrix, updates the pose on one
// shared multiplier and walks the recorded joints to emit Jacobian columns.
// ============================================================================
module dgj_back import dgj_pkg::*; #(
    parameter int MAX_JOINTS = MAX_JOINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  t_job               i_job,
    output logic               o_job_pop,
    output logic               o_cor_start,
    output logic signed [33:0] o_cor_turn,
    output logic signed [33:0] o_cor_twist,
    input  t_cor_stat          i_cor_t_stat,
    input  t_sc                i_cor_t,
    input  t_cor_stat          i_cor_a_stat,
    input  t_sc                i_cor_a,
    output logic               empty,
    input  logic               pop,
    output t_out_item          o_result
);
    localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int CW = $clog2(MAX_JOINTS + 1);
    localparam int RW = 193;

    t_back_state        r_state;
    t_back_state        n_state;
    t_mode              r_mode;
    logic [2:0]         r_k;
    logic [1:0]         r_r;
    logic [1:0]         r_c;
    logic [1:0]         r_t;
    logic signed [31:0] r_pose  [12];
    logic signed [31:0] r_fresh [12];
    logic signed [31:0] r_lk    [12];
    logic signed [31:0] r_len;
    logic               r_fin;
    logic signed [51:0] r_acc;
    logic signed [63:0] r_prod;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_j;
    logic signed [31:0] r_u [3];
    logic signed [31:0] r_e [3];
    logic signed [31:0] r_col [3];
    logic               r_kind;
    logic               r_ovalid;
    t_out_item          r_out;

    logic [RW-1:0]      s_wdata;
    logic [RW-1:0]      s_rdata;
    logic               s_we;
    logic signed [31:0] s_a;
    logic signed [31:0] s_b;
    logic signed [47:0] s_q;
    logic signed [51:0] s_sum;
    logic signed [51:0] s_fin_sum;
    logic [3:0]         s_pidx;
    logic               s_emit;
    logic               s_last;
    logic               s_prod_done;

    dgj_ram #(.WIDTH(RW), .DEPTH(MAX_JOINTS)) u_store (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (s_wdata),
        .i_raddr (r_j[AW-1:0]),
        .o_rdata (s_rdata)
    );

    // Store word: kind, axis z y x, origin z y x.
    assign s_wdata = {i_job.rev, r_pose[10], r_pose[6], r_pose[2],
                      r_pose[11], r_pose[7], r_pose[3]};

    assign o_job_pop   = (r_state == B_IDLE) && i_job_valid;
    assign o_cor_start = o_job_pop;
    assign o_cor_turn  = i_job.turn;
    assign o_cor_twist = 34'(i_job.twist);
    assign s_we        = o_job_pop && (r_cnt < CW'(MAX_JOINTS));
    assign s_emit      = (r_state == B_EMIT) && (!r_ovalid || pop);
    assign s_last      = (r_j + CW'(1) == r_cnt);
    assign s_pidx      = {r_r, 2'b00} + 4'(r_t);
    assign s_prod_done = (r_t == 2'd2) && (r_c == 2'd3) && (r_r == 2'd2);

    // Operand selection for the shared multiplier.
    always_comb begin
        s_a = r_lk[4];
        s_b = r_lk[10];
        case (r_mode)
            M_LINK: begin
                case (r_k)
                    3'd0: begin s_a = r_lk[4]; s_b = r_lk[10]; end
                    3'd1: begin s_a = r_lk[4]; s_b = r_lk[9];  end
                    3'd2: begin s_a = r_len;   s_b = r_lk[0];  end
                    3'd3: begin s_a = r_lk[0]; s_b = r_lk[10]; end
                    3'd4: begin s_a = r_lk[0]; s_b = r_lk[9];  end
                    default: begin s_a = r_len; s_b = r_lk[4]; end
                endcase
            end
            M_PROD: begin
                s_a = r_pose[s_pidx];
                s_b = r_lk[{r_t, r_c}];
            end
            M_COL: begin
                case (r_k)
                    3'd0: begin s_a = r_u[1]; s_b = r_e[2]; end
                    3'd1: begin s_a = r_u[2]; s_b = r_e[1]; end
                    3'd2: begin s_a = r_u[2]; s_b = r_e[0]; end
                    3'd3: begin s_a = r_u[0]; s_b = r_e[2]; end
                    3'd4: begin s_a = r_u[0]; s_b = r_e[1]; end
                    default: begin s_a = r_u[1]; s_b = r_e[0]; end
                endcase
            end
            default: begin
            end
        endcase
        s_q       = qround(r_prod);
        s_sum     = ((r_t == 2'd0) ? 52'sd0 : r_acc) + 52'(s_q);
        s_fin_sum = s_sum + ((r_c == 2'd3) ? 52'(r_pose[{r_r, 2'b11}]) : 52'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: if (i_job_valid) n_state = B_TRIG;
            B_TRIG: begin
                if (i_cor_t_stat.valid && i_cor_a_stat.valid) begin
                    n_state = B_MUL;
                end
            end
            B_MUL: n_state = B_ACC;
            B_ACC: begin
                n_state = B_MUL;
                if (r_mode == M_PROD && s_prod_done) begin
                    n_state = B_UPDATE;
                end else if (r_mode == M_COL && r_k == 3'd5) begin
                    n_state = B_EMIT;
                end
            end
            B_UPDATE: n_state = r_fin ? B_RD : B_IDLE;
            B_RD:     n_state = B_RDW;
            B_RDW:    n_state = s_rdata[RW-1] ? B_MUL : B_EMIT;
            B_EMIT: begin
                if (s_emit) begin
                    n_state = s_last ? B_IDLE : B_RD;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_len <= i_job.len;
                r_fin <= i_job.fin;
                r_lk[11] <= i_job.depth;
            end
            B_TRIG: begin
                r_lk[0]  <= i_cor_t.cos_v;
                r_lk[4]  <= i_cor_t.sin_v;
                r_lk[8]  <= '0;
                r_lk[9]  <= i_cor_a.sin_v;
                r_lk[10] <= i_cor_a.cos_v;
                r_mode   <= M_LINK;
                r_k      <= 3'd0;
                r_r      <= 2'd0;
                r_c      <= 2'd0;
                r_t      <= 2'd0;
            end
            B_MUL: begin
                r_prod <= s_a * s_b;
            end
            B_ACC: begin
                case (r_mode)
                    M_LINK: begin
                        case (r_k)
                            3'd0: r_lk[1] <= sat32(-64'(s_q));
                            3'd1: r_lk[2] <= sat32(64'(s_q));
                            3'd2: r_lk[3] <= sat32(64'(s_q));
                            3'd3: r_lk[5] <= sat32(64'(s_q));
                            3'd4: r_lk[6] <= sat32(-64'(s_q));
                            default: r_lk[7] <= sat32(64'(s_q));
                        endcase
                        r_k <= r_k + 3'd1;
                        if (r_k == 3'd5) begin
                            r_mode <= M_PROD;
                        end
                    end
                    M_PROD: begin
                        r_acc <= s_sum;
                        if (r_t == 2'd2) begin
                            r_fresh[{r_r, r_c}] <= sat32(64'(s_fin_sum));
                            r_t <= 2'd0;
                            r_c <= r_c + 2'd1;
                            if (r_c == 2'd3) begin
                                r_r <= r_r + 2'd1;
                            end
                        end else begin
                            r_t <= r_t + 2'd1;
                        end
                    end
                    M_COL: begin
                        // Even steps take the first product, odd steps subtract.
                        if (!r_k[0]) begin
                            r_acc <= 52'(s_q);
                        end else begin
                            r_col[r_k[2:1]] <= sat32(64'(r_acc) - 64'(s_q));
                        end
                        r_k <= r_k + 3'd1;
                    end
                    default: begin
                    end
                endcase
            end
            B_RDW: begin
                r_kind <= s_rdata[RW-1];
                r_u[0] <= s_rdata[127:96];
                r_u[1] <= s_rdata[159:128];
                r_u[2] <= s_rdata[191:160];
                r_e[0] <= sat32(64'(r_pose[3])  - 64'($signed(s_rdata[31:0])));
                r_e[1] <= sat32(64'(r_pose[7])  - 64'($signed(s_rdata[63:32])));
                r_e[2] <= sat32(64'(r_pose[11]) - 64'($signed(s_rdata[95:64])));
                r_mode <= M_COL;
                r_k    <= 3'd0;
            end
            default: begin
            end
        endcase

        if (s_emit) begin
            if (r_kind) begin
                r_out.lin_x <= r_col[0];
                r_out.lin_y <= r_col[1];
                r_out.lin_z <= r_col[2];
                r_out.ang_x <= r_u[0];
                r_out.ang_y <= r_u[1];
                r_out.ang_z <= r_u[2];
            end else begin
                r_out.lin_x <= r_u[0];
                r_out.lin_y <= r_u[1];
                r_out.lin_z <= r_u[2];
                r_out.ang_x <= '0;
                r_out.ang_y <= '0;
                r_out.ang_z <= '0;
            end
            r_out.column_index <= 4'(r_j);
            r_out.last_column  <= s_last;
        end

        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_j      <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 12; i++) begin
                r_pose[i] <= ((i % 5) == 0 && i != 15) ? Q_ONE : 32'sd0;
            end
        end else begin
            if (s_we) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (r_state == B_UPDATE) begin
                r_pose <= r_fresh;
                r_j    <= '0;
            end
            if (s_emit) begin
                r_j <= r_j + CW'(1);
                if (s_last) begin
                    r_cnt <= '0;
                    for (int i = 0; i < 12; i++) begin
                        r_pose[i] <= ((i % 5) == 0) ? Q_ONE : 32'sd0;
                    end
                end
            end
            if (s_emit) begin
                r_ovalid <= 1'b1;
            end else if (pop && r_ovalid) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign empty    = !r_ovalid;
    assign o_result = r_out;
endmodule

// ===== rtl/dh_geometric_jacobian.sv =====
// ============================================================================
// dh_geometric_jacobian
// Geometric Jacobian of a Denavit-Hartenberg serial chain, one joint a word.
// ============================================================================
// The back end takes a joint and waits until both sine/cosine units have run
// side by side (16 reduction steps, fold, 16 rotations, rounding, capture), then
// forms 42 products on the one shared multiplier and loads the new pose. On the
// last joint each column is read back from the store; a revolute column adds 6
// products for its cross product. A new joint is taken only once the last is done.
// Reset (synchronous, active low) sets the pose to identity and empties all queues.
// ============================================================================
module dh_geometric_jacobian import dgj_pkg::*; #(
    parameter int MAX_JOINTS = MAX_JOINTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);
    // Front end: a two-word queue of joints with the varying DH term resolved.
    logic               s_job_valid;
    t_job               s_job;
    logic               s_job_pop;

    // Sine/cosine units for the joint angle and the link twist.
    logic               s_cor_start;
    logic signed [33:0] s_cor_turn;
    logic signed [33:0] s_cor_twist;
    t_cor_stat          s_cor_t_stat;
    t_cor_stat          s_cor_a_stat;
    t_sc                s_cor_t;
    t_sc                s_cor_a;

    dgj_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_job_valid (s_job_valid),
        .o_job       (s_job),
        .i_job_pop   (s_job_pop)
    );

    dgj_cordic u_cor_turn (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_cor_start),
        .i_angle (s_cor_turn),
        .o_stat  (s_cor_t_stat),
        .o_sc    (s_cor_t)
    );

    dgj_cordic u_cor_twist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_cor_start),
        .i_angle (s_cor_twist),
        .o_stat  (s_cor_a_stat),
        .o_sc    (s_cor_a)
    );

    // Back end: frame recording, pose update and column output register.
    dgj_back #(.MAX_JOINTS(MAX_JOINTS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (s_job_valid),
        .i_job        (s_job),
        .o_job_pop    (s_job_pop),
        .o_cor_start  (s_cor_start),
        .o_cor_turn   (s_cor_turn),
        .o_cor_twist  (s_cor_twist),
        .i_cor_t_stat (s_cor_t_stat),
        .i_cor_t      (s_cor_t),
        .i_cor_a_stat (s_cor_a_stat),
        .i_cor_a      (s_cor_a),
        .empty        (empty),
        .pop          (pop),
        .o_result     (o_result)
    );

    // The back end only takes a joint that the front end holds.
    a_pop_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_job_pop |-> s_job_valid)
        else $error("joint taken from an empty queue");

    // A sine/cosine start never lands on a unit that is still working.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cor_start |-> (!s_cor_t_stat.busy && !s_cor_a_stat.busy))
        else $error("sine/cosine restarted while busy");

    // A started unit drops its old result before the back end can use it.
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cor_start |=> (!s_cor_t_stat.valid && !s_cor_a_stat.valid))
        else $error("stale sine/cosine result after start");
endmodule

// ===== verif/dh_geometric_jacobian_chk.sv =====
// ============================================================================
// dh_geometric_jacobian_chk
// Watches both queue ports of the Jacobian block. It keeps its own pose and
// joint records, predicts every Jacobian column and compares the columns that
// are popped, field by field, with the oldest column it predicted.
// ============================================================================
module dh_geometric_jacobian_chk import dgj_pkg::*; #(
    parameter int MAX_JOINTS = MAX_JOINTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  logic      i_full,
    input  t_in_item  i_item,
    input  logic      i_empty,
    input  logic      i_pop,
    input  t_out_item i_result,
    output int        o_failures,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint TWO_PI  = 411775;
    localparam longint PI_Q    = 205887;
    localparam longint HALF_PI = 102944;

    longint    pose[12];
    longint    origin_rec[MAX_JOINTS*3];
    longint    axis_rec[MAX_JOINTS*3];
    bit        kind_rec[MAX_JOINTS];
    int        joints_seen;
    t_out_item column_q[$];
    int        failures;

    assign o_failures = failures;
    assign o_pending  = column_q.size();

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qprod(input longint p, input longint r);
        return (p * r + 32768) >>> 16;
    endfunction

    task automatic trig(input longint ang, output longint sn, output longint cs);
        longint atan_lut[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                 256, 128, 64, 32, 16, 8, 4, 2};
        longint z, x, y, xs, ys;
        bit flip;
        z = ang % TWO_PI;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z < 0) z += TWO_PI;
        if (z > PI_Q) z -= TWO_PI;
        if (z > HALF_PI) begin
            z -= PI_Q;
            flip = 1;
        end else if (z < -HALF_PI) begin
            z += PI_Q;
            flip = 1;
        end
        for (int k = 0; k < 16; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_lut[k];
            end else begin
                x += ys; y -= xs; z += atan_lut[k];
            end
        end
        x = (x + 8192) >>> 14;
        y = (y + 8192) >>> 14;
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endtask

    task automatic pose_home();
        foreach (pose[i]) pose[i] = 0;
        pose[0] = 65536;
        pose[5] = 65536;
        pose[10] = 65536;
    endtask

    task automatic advance_chain(input t_in_item it);
        longint jv, len, tw, dz, th, zo, turn, depth, sth, cth, sal, cal, acc;
        longint lk[3][4];
        longint nxt[12];
        longint ux, uy, uz, ex, ey, ez;
        t_out_item col;
        jv = it.joint_value; len = it.link_length; tw = it.link_twist;
        dz = it.link_offset; th = it.joint_angle; zo = it.joint_zero_offset;
        if (joints_seen < MAX_JOINTS) begin
            for (int r = 0; r < 3; r++) begin
                origin_rec[joints_seen*3+r] = pose[r*4+3];
                axis_rec[joints_seen*3+r]   = pose[r*4+2];
            end
            kind_rec[joints_seen] = it.revolute;
            joints_seen++;
        end
        if (it.revolute) begin
            turn = th + jv + zo;
            depth = dz;
        end else begin
            turn = th;
            depth = clamp32(dz + jv + zo);
        end
        trig(turn, sth, cth);
        trig(tw, sal, cal);
        lk[0][0] = cth;
        lk[0][1] = clamp32(-qprod(sth, cal));
        lk[0][2] = clamp32(qprod(sth, sal));
        lk[0][3] = clamp32(qprod(len, cth));
        lk[1][0] = sth;
        lk[1][1] = clamp32(qprod(cth, cal));
        lk[1][2] = clamp32(-qprod(cth, sal));
        lk[1][3] = clamp32(qprod(len, sth));
        lk[2][0] = 0;
        lk[2][1] = sal;
        lk[2][2] = cal;
        lk[2][3] = depth;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
                acc = qprod(pose[r*4], lk[0][c]) + qprod(pose[r*4+1], lk[1][c])
                    + qprod(pose[r*4+2], lk[2][c]);
                if (c == 3) acc += pose[r*4+3];
                nxt[r*4+c] = clamp32(acc);
            end
        end
        pose = nxt;
        if (!it.last_joint) return;
        for (int j = 0; j < joints_seen; j++) begin
            ux = axis_rec[j*3]; uy = axis_rec[j*3+1]; uz = axis_rec[j*3+2];
            ex = clamp32(pose[3]  - origin_rec[j*3]);
            ey = clamp32(pose[7]  - origin_rec[j*3+1]);
            ez = clamp32(pose[11] - origin_rec[j*3+2]);
            if (kind_rec[j]) begin
                col.lin_x = clamp32(qprod(uy, ez) - qprod(uz, ey));
                col.lin_y = clamp32(qprod(uz, ex) - qprod(ux, ez));
                col.lin_z = clamp32(qprod(ux, ey) - qprod(uy, ex));
                col.ang_x = ux; col.ang_y = uy; col.ang_z = uz;
            end else begin
                col.lin_x = ux; col.lin_y = uy; col.lin_z = uz;
                col.ang_x = 0; col.ang_y = 0; col.ang_z = 0;
            end
            col.column_index = j[3:0];
            col.last_column  = (j + 1 == joints_seen);
            column_q.push_back(col);
        end
        pose_home();
        joints_seen = 0;
    endtask

    task automatic compare_column(input t_out_item got);
        t_out_item exp_col;
        if (column_q.size() == 0) begin
            $error("column popped with none predicted: %p", got);
            failures++;
            return;
        end
        exp_col = column_q.pop_front();
        if (got.lin_x !== exp_col.lin_x) begin
            $error("lin_x expected %0d actual %0d", exp_col.lin_x, got.lin_x); failures++;
        end
        if (got.lin_y !== exp_col.lin_y) begin
            $error("lin_y expected %0d actual %0d", exp_col.lin_y, got.lin_y); failures++;
        end
        if (got.lin_z !== exp_col.lin_z) begin
            $error("lin_z expected %0d actual %0d", exp_col.lin_z, got.lin_z); failures++;
        end
        if (got.ang_x !== exp_col.ang_x) begin
            $error("ang_x expected %0d actual %0d", exp_col.ang_x, got.ang_x); failures++;
        end
        if (got.ang_y !== exp_col.ang_y) begin
            $error("ang_y expected %0d actual %0d", exp_col.ang_y, got.ang_y); failures++;
        end
        if (got.ang_z !== exp_col.ang_z) begin
            $error("ang_z expected %0d actual %0d", exp_col.ang_z, got.ang_z); failures++;
        end
        if (got.column_index !== exp_col.column_index) begin
            $error("column_index expected %0d actual %0d",
                   exp_col.column_index, got.column_index);
            failures++;
        end
        if (got.last_column !== exp_col.last_column) begin
            $error("last_column expected %0d actual %0d",
                   exp_col.last_column, got.last_column);
            failures++;
        end
    endtask

    initial begin
        failures = 0;
        joints_seen = 0;
        pose_home();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pose_home();
            joints_seen = 0;
            column_q.delete();
        end else begin
            if (i_pop && !i_empty) compare_column(i_result);
            if (i_push && !i_full) advance_chain(i_item);
        end
    end
endmodule

// ===== verif/dh_geometric_jacobian_tb.sv =====
// ============================================================================
// dh_geometric_jacobian_tb
// Drives chains of DH joints into the Jacobian block, one word per joint,
// with random gaps on the push side and random stalls on the pop side. The
// checker beside the block predicts and compares every column.
// ============================================================================
module dh_geometric_jacobian_tb import dgj_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    t_in_item  i_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item o_result;
    int        failures;
    int        pending;

    // Set at the rising edge when the pop side took a word, read at the falling edge.
    logic      col_taken = 1'b0;
    int        pop_wait = 0;

    always #6 i_clk = ~i_clk;

    dh_geometric_jacobian uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_result(o_result)
    );

    dh_geometric_jacobian_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_full(full), .i_item(i_item),
        .i_empty(empty), .i_pop(pop), .i_result(o_result),
        .o_failures(failures), .o_pending(pending)
    );

    always @(posedge i_clk) col_taken <= pop && !empty;

    // Pop side: after every taken word it draws a random wait and holds pop low until it runs out.
    always @(negedge i_clk) begin
        if (col_taken) begin
            pop_wait = $urandom_range(0, 8);
        end
        if (pop_wait > 0) begin
            pop_wait--;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // An angle near the interesting range, so most sines and cosines fold in
    // different quadrants; now and then any 32-bit pattern.
    function automatic logic signed [31:0] pick_angle();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $signed($urandom_range(0, 2 * 411775)) - 411775;
    endfunction

    // A length of a few units; sometimes full range so saturation is reached.
    function automatic logic signed [31:0] pick_length();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $signed($urandom_range(0, 2 * 262144)) - 262144;
    endfunction

    function automatic t_in_item make_joint(input logic fin);
        t_in_item it;
        it.revolute          = $urandom_range(0, 3) != 0;
        it.joint_value       = it.revolute ? pick_angle() : pick_length();
        it.link_length       = pick_length();
        it.link_twist        = pick_angle();
        it.link_offset       = pick_length();
        it.joint_angle       = pick_angle();
        it.joint_zero_offset = ($urandom_range(0, 2) == 0) ? pick_angle() : 32'sd0;
        it.last_joint        = fin;
        return it;
    endfunction

    // Offers one joint word after a gap and holds it until the block takes it.
    // With no gap push stays high, so it is never lowered and raised in one step.
    task automatic send_joint(input t_in_item it);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 4) == 0) gap = 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_item <= it;
        push   <= 1'b1;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    task automatic send_chain(input int len);
        for (int j = 0; j < len; j++) send_joint(make_joint(j == len - 1));
    endtask

    initial begin
        t_in_item it;
        int sent;
        int len;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // A lone revolute joint at rest: one column from the identity pose.
        it = '0;
        it.revolute = 1'b1;
        it.last_joint = 1'b1;
        send_joint(it);

        // Every field at its positive extreme, then at its negative extreme,
        // so the reduction of huge angles and all saturations are hit.
        it = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
               32'sh7fffffff, 32'sh7fffffff, 1'b1, 1'b0};
        send_joint(it);
        it.revolute = 1'b0;
        send_joint(it);
        it = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
               32'sh80000000, 32'sh80000000, 1'b0, 1'b0};
        send_joint(it);
        it.revolute = 1'b1;
        it.last_joint = 1'b1;
        send_joint(it);

        // Angles right at the fold points of the sine/cosine reduction.
        it = '0;
        it.revolute = 1'b1;
        it.link_length = 32'sd65536;
        it.joint_angle = 32'sd102944;
        send_joint(it);
        it.joint_angle = -32'sd102944;
        it.link_twist  = 32'sd205887;
        send_joint(it);
        it.joint_angle = 32'sd205888;
        it.link_twist  = 32'sd411775;
        send_joint(it);
        it.revolute = 1'b0;
        it.joint_value = 32'sd131072;
        it.last_joint = 1'b1;
        send_joint(it);
        sent = 9;

        // Random chains: mostly short, a few that run past the joint limit
        // so the unrecorded joints still move the end point.
        while (sent < 110) begin
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(16, 19);
                1, 2:    len = $urandom_range(7, 15);
                default: len = $urandom_range(1, 6);
            endcase
            send_chain(len);
            sent += len;
        end
        push <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/dgj_pkg.sv
rtl/dgj_ram.sv
rtl/dgj_front.sv
rtl/dgj_cordic.sv
rtl/dgj_back.sv
rtl/dh_geometric_jacobian.sv
verif/dh_geometric_jacobian_chk.sv
verif/dh_geometric_jacobian_tb.sv
